/* src/tks_pkg.sv */
// Shared types, constants and helpers for the top-k score keeper.
// No dependencies; every other file imports this package.
`default_nettype none

package tks_pkg;

    parameter int KEEP_MAX = 16;
    localparam int CNT_W   = $clog2(KEEP_MAX + 1);
    localparam int KC_W    = 5;
    localparam int KEY_W   = 32;
    localparam int SCORE_W = 16;

    localparam logic [KC_W-1:0]           KC_RESET = 5'd16;
    localparam logic signed [SCORE_W-1:0] Q_ONE    = 16'sd16384;
    localparam logic signed [SCORE_W-1:0] Q_MINUS  = -16'sd16384;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    // Insert command from the top level to the sorted store.
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
    } ins_cmd_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [KC_W-1:0] kc);
        logic [31:0] w;
        w = 32'(kc);
        if (w == 32'd0)
        begin
            w = 32'd1;
        end
        else if (w > 32'(KEEP_MAX))
        begin
            w = 32'(KEEP_MAX);
        end
        return CNT_W'(w);
    endfunction

    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [SCORE_W-1:0] s);
        logic signed [SCORE_W-1:0] r;
        r = s;
        if (s > Q_ONE)
        begin
            r = Q_ONE;
        end
        else if (s < Q_MINUS)
        begin
            r = Q_MINUS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/tks_item_if.sv */
// Input channel: one scored item per word, valid/ready handshake.
// Depends on tks_pkg for field widths.
`default_nettype none

interface tks_item_if import tks_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KEY_W-1:0]          item_key;
    logic signed [SCORE_W-1:0] score;
    logic                      end_of_set;

    modport source (output valid, item_key, score, end_of_set, input ready);
    modport sink   (input valid, item_key, score, end_of_set, output ready);
endinterface

`default_nettype wire

/* src/tks_result_if.sv */
// Output channel: one retained entry per word, valid/ready handshake.
// Depends on tks_pkg for field widths.
`default_nettype none

interface tks_result_if import tks_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KEY_W-1:0]          out_key;
    logic signed [SCORE_W-1:0] out_score;
    logic                      last_of_run;

    modport source (output valid, out_key, out_score, last_of_run, input ready);
    modport sink   (input valid, out_key, out_score, last_of_run, output ready);
endinterface

`default_nettype wire

/* src/tks_sorted_store.sv */
// Sorted register chain holding the retained entries, minimum at index 0.
// Depends on tks_pkg.
`default_nettype none

module tks_sorted_store import tks_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ins_cmd_t         ins,
    input  wire logic [CNT_W-1:0] keep_eff,
    output entry_t                snap [KEEP_MAX],
    output logic [CNT_W-1:0]      snap_total
);

    entry_t           ent_reg  [KEEP_MAX];
    entry_t           ent_next [KEEP_MAX];
    entry_t           lower    [KEEP_MAX];
    entry_t           upper    [KEEP_MAX];
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic             le    [KEEP_MAX];
    logic             le_dn [KEEP_MAX];
    logic             le_up [KEEP_MAX];
    logic             grow;
    logic             replace;
    logic             sorted_ok;
    entry_t           new_ent;

    assign new_ent = '{key: ins.key, score: ins.score};
    assign grow    = total_reg < keep_eff;
    assign replace = !grow && (total_reg != '0) && (ent_reg[0].score < ins.score);

    // Each entry compares against the new score in parallel; the chain is sorted,
    // so the compare flags form a run of ones followed by zeros.
    always_comb
    begin
        for (int i = 0; i < KEEP_MAX; i++)
        begin
            le[i] = (CNT_W'(i) < total_reg) && (ent_reg[i].score <= ins.score);
        end
        le_dn[0] = 1'b1;
        lower[0] = ent_reg[0];
        for (int i = 1; i < KEEP_MAX; i++)
        begin
            le_dn[i] = le[i-1];
            lower[i] = ent_reg[i-1];
        end
        for (int i = 0; i < KEEP_MAX - 1; i++)
        begin
            le_up[i] = le[i+1];
            upper[i] = ent_reg[i+1];
        end
        le_up[KEEP_MAX-1] = 1'b0;
        upper[KEEP_MAX-1] = ent_reg[KEEP_MAX-1];
    end

    always_comb
    begin
        for (int i = 0; i < KEEP_MAX; i++)
        begin
            ent_next[i] = ent_reg[i];
            if (grow)
            begin
                // Open a slot above every entry that ranks at or below the new one.
                if (le[i])
                    ent_next[i] = ent_reg[i];
                else if (le_dn[i])
                    ent_next[i] = new_ent;
                else
                    ent_next[i] = lower[i];
            end
            else if (replace)
            begin
                // Drop the minimum, slide the lower part down, drop the new one in.
                if (le_up[i])
                    ent_next[i] = upper[i];
                else if (le[i])
                    ent_next[i] = new_ent;
                else
                    ent_next[i] = ent_reg[i];
            end
            snap[i] = ent_next[i];
        end
        snap_total = grow ? total_reg + 1'b1 : total_reg;
        total_next = total_reg;
        if (ins.valid)
        begin
            total_next = ins.last ? '0 : snap_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins.valid)
        begin
            for (int i = 0; i < KEEP_MAX; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
        end
    end

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < KEEP_MAX; i++)
        begin
            if ((CNT_W'(i) < total_reg) && (ent_reg[i-1].score > ent_reg[i].score))
                sorted_ok = 1'b0;
        end
    end

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
        else $error("sorted store lost its ascending order");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(KEEP_MAX))
        else $error("store count beyond capacity");
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (ins.valid && ins.last) |=> (total_reg == '0))
        else $error("store not emptied after end of set");

endmodule

`default_nettype wire

/* src/top_k_score_keeper.sv */
// Top-k score keeper: accepts scored words and retains the best keep_count of each set.
// Latency: an end-of-set word is accepted and its first result is valid on the next cycle.
// Throughput: one input word per cycle, but an end-of-set word waits until the drain
// buffer is empty; results drain one per cycle while the result channel is ready.
// Reset clears the store count, the drain count and sets keep_count to 16.
// Depends on tks_pkg, tks_item_if, tks_result_if and tks_sorted_store.
`default_nettype none

module top_k_score_keeper import tks_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [KC_W-1:0] cfg_wdata,
    tks_item_if.sink             items,
    tks_result_if.source         results
);

    // Configuration register; the effective count is clamped to 1..KEEP_MAX.
    logic [KC_W-1:0]  keep_count_reg;
    logic [CNT_W-1:0] keep_eff;

    // Drain buffer: a copy of the sorted store taken when the set closes. Entry 0
    // is always the word offered on the result channel, so the buffer doubles as
    // the output register and parts the result side from the insert path.
    entry_t           drain_reg  [KEEP_MAX];
    entry_t           drain_next [KEEP_MAX];
    logic [CNT_W-1:0] drain_cnt_reg;
    logic [CNT_W-1:0] drain_cnt_next;

    ins_cmd_t         ins;
    entry_t           snap [KEEP_MAX];
    logic [CNT_W-1:0] snap_total;
    logic             in_fire;
    logic             out_fire;

    assign keep_eff = eff_count(keep_count_reg);

    // Ordinary words are always taken; a word that closes a set needs an empty drain
    // buffer, because it hands the whole store over to it.
    assign items.ready = !items.end_of_set || (drain_cnt_reg == '0);
    assign in_fire     = items.valid && items.ready;
    assign out_fire    = results.valid && results.ready;

    assign ins.valid = in_fire;
    assign ins.last  = items.end_of_set;
    assign ins.key   = items.item_key;
    assign ins.score = sat_score(items.score);

    tks_sorted_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ins        (ins),
        .keep_eff   (keep_eff),
        .snap       (snap),
        .snap_total (snap_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KC_RESET;
        end
        else if (cfg_we)
        begin
            keep_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEEP_MAX; i++)
        begin
            drain_next[i] = drain_reg[i];
        end
        drain_cnt_next = drain_cnt_reg;
        if (in_fire && items.end_of_set)
        begin
            // Drain buffer is empty here, so loading never collides with a shift.
            for (int i = 0; i < KEEP_MAX; i++)
            begin
                drain_next[i] = snap[i];
            end
            drain_cnt_next = snap_total;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < KEEP_MAX - 1; i++)
            begin
                drain_next[i] = drain_reg[i+1];
            end
            drain_cnt_next = drain_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_cnt_reg <= '0;
        end
        else
        begin
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEEP_MAX; i++)
        begin
            drain_reg[i] <= drain_next[i];
        end
    end

    assign results.valid       = drain_cnt_reg != '0;
    assign results.out_key     = drain_reg[0].key;
    assign results.out_score   = drain_reg[0].score;
    assign results.last_of_run = drain_cnt_reg == CNT_W'(1);

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && items.end_of_set && (snap_total != '0)) |=> results.valid)
        else $error("closed set with entries produced no result word");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && results.last_of_run) |=> !results.valid)
        else $error("result words continued past the flagged last word");
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_cnt_reg <= CNT_W'(KEEP_MAX))
        else $error("drain count beyond capacity");

endmodule

`default_nettype wire
